FILE: design/md5_pkg.sv
// ============================================================================
// md5_pkg: shared types, constants and round tables for the MD5 digest block
// Holds the sequencer state type, the working register bundle, the initial
// chaining values and the per-round constant, shift and word-index tables.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PAD,
        ST_PREP,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } md5_state_t;

    // Working registers of one compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_work_t;

    // Initial chaining values
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic [7:0] PAD_BYTE        = 8'h80;
    localparam logic [5:0] LEN_POS         = 6'd56;
    localparam logic [5:0] LAST_POS        = 6'd63;
    localparam logic [3:0] BLOCK_LAST_WORD = 4'd15;
    localparam logic [2:0] FULL_COUNT      = 3'd4;
    localparam logic [5:0] LAST_ROUND      = 6'd63;
    localparam logic [1:0] LAST_INDEX      = 2'd3;

    // Additive constant of each round
    function automatic logic [31:0] md5_sine(input logic [5:0] round);
        logic [31:0] k;
        unique case (round)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    // Left rotate amount of each round
    function automatic logic [4:0] md5_shift(input logic [5:0] round);
        logic [4:0] s;
        unique case ({round[5:4], round[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word used by each round (arithmetic is modulo 16)
    function automatic logic [3:0] md5_msg_index(input logic [5:0] round);
        logic [3:0] i;
        logic [3:0] g;
        i = round[3:0];
        unique case (round[5:4])
            2'd0: g = i;
            2'd1: g = 4'((i << 2) + i + 4'd1);
            2'd2: g = 4'((i << 1) + i + 4'd5);
            2'd3: g = 4'((i << 3) - i);
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: design/md5_round.sv
// ============================================================================
// md5_round: one MD5 round step
// Computes the new B word from the working registers, the selected message
// word and the round number; the caller rotates the other three words.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module md5_round
    import md5_pkg::*;
(
    input  md5_work_t   work,
    input  logic [31:0] msg_word,
    input  logic [5:0]  round,
    output logic [31:0] new_b
);

    logic [31:0] func_val;
    logic [31:0] sum_val;
    logic [63:0] rot_wide;

    // Select the round's boolean function
    always_comb
    begin
        unique case (round[5:4])
            2'd0: func_val = (work.b & work.c) | (~work.b & work.d);
            2'd1: func_val = (work.d & work.b) | (~work.d & work.c);
            2'd2: func_val = work.b ^ work.c ^ work.d;
            2'd3: func_val = work.c ^ (work.b | ~work.d);
        endcase
    end

    // Add, rotate, add
    always_comb
    begin
        sum_val  = work.a + func_val + md5_sine(round) + msg_word;
        rot_wide = {sum_val, sum_val} << md5_shift(round);
        new_b    = work.b + rot_wide[63:32];
    end

endmodule

`default_nettype wire

FILE: design/md5_message_digest_top.sv
// ============================================================================
// md5_message_digest_top: MD5 hash of a word stream
// Packs message bytes into a 16-word block buffer, runs the 64 rounds on one
// shared round unit, pads on the end beat and returns the digest as four beats.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid / in_stall   data_word, byte_count, end_of_message
//  out      source     out_valid / out_stall digest_word, word_index, last_word
//
//  An input beat is taken only in idle; the block buffer is then written a whole
//  word at once for an aligned full word, or byte by byte when unaligned or short.
//  Each full block then runs a setup step, the 64 rounds through the one round
//  unit and a chaining add. The end beat adds 9 to 72 pad bytes, written byte by
//  byte, and the 4 digest beats. Reset loads the initial chaining values;
//  out_stall holds the current beat.
//
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest_top
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    md5_state_t  state_reg, state_next;

    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [63:0] len_reg, len_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        eom_reg, eom_next;
    logic        in_pad_reg, in_pad_next;
    logic        len_phase_reg, len_phase_next;
    logic        pad_done_reg, pad_done_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] part_reg, part_next;
    md5_work_t   work_reg, work_next;
    logic [31:0] mem_rd_reg;

    logic [31:0] msg_mem [16];

    logic        in_fire;
    logic        out_fire;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic        block_full;
    logic        full_word;
    logic        is_len;
    logic [7:0]  pad_byte;
    logic [7:0]  ins_byte;
    logic [63:0] len_bits;
    logic [31:0] round_b;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // Shared round unit
    md5_round u_round (
        .work     (work_reg),
        .msg_word (mem_rd_reg),
        .round    (round_reg),
        .new_b    (round_b)
    );

    // Pad byte selection
    always_comb
    begin
        len_bits = {len_reg[60:0], 3'b000};
        is_len   = in_pad_reg && (pos_reg >= LEN_POS) && (len_phase_reg || pos_reg == LEN_POS);
        if (!in_pad_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (is_len)
        begin
            pad_byte = len_bits[{pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Block buffer write path
    always_comb
    begin
        full_word = (state_reg == ST_LOAD) && (pos_reg[1:0] == 2'd0) && (cnt_reg == FULL_COUNT);
        ins_byte  = (state_reg == ST_PAD) ? pad_byte : data_reg[7:0];
        part_next = part_reg;
        part_next[{pos_reg[1:0], 3'b000} +: 8] = ins_byte;
        wr_addr   = pos_reg[5:2];
        if (full_word)
        begin
            wr_en   = 1'b1;
            wr_data = data_reg;
        end
        else
        begin
            wr_en   = ((state_reg == ST_LOAD) || (state_reg == ST_PAD)) && (pos_reg[1:0] == 2'd3);
            wr_data = part_next;
        end
        block_full = wr_en && (wr_addr == BLOCK_LAST_WORD);
        rd_addr    = (state_reg == ST_PREP) ? 4'd0 : md5_msg_index(6'(round_reg + 6'd1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_count != 3'd0)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                priority if (block_full)
                begin
                    state_next = ST_PREP;
                end
                else if (cnt_next != 3'd0)
                begin
                    state_next = ST_LOAD;
                end
                else if (eom_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                priority if (pad_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (in_pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (cnt_reg != 3'd0)
                begin
                    state_next = ST_LOAD;
                end
                else if (eom_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire && (out_idx_reg == LAST_INDEX))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    // Datapath next values
    always_comb
    begin
        chain_next     = chain_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        round_next     = round_reg;
        cnt_next       = cnt_reg;
        eom_next       = eom_reg;
        in_pad_next    = in_pad_reg;
        len_phase_next = len_phase_reg;
        pad_done_next  = pad_done_reg;
        out_idx_next   = out_idx_reg;
        data_next      = data_reg;
        work_next      = work_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the beat; counts above four mean four
                if (in_fire)
                begin
                    data_next      = data_word;
                    cnt_next       = byte_count[2] ? FULL_COUNT : byte_count;
                    eom_next       = end_of_message;
                    in_pad_next    = 1'b0;
                    len_phase_next = 1'b0;
                    pad_done_next  = 1'b0;
                end
            end
            ST_LOAD:
            begin
                if (full_word)
                begin
                    cnt_next = 3'd0;
                    pos_next = 6'(pos_reg + 6'd4);
                    len_next = len_reg + 64'd4;
                end
                else
                begin
                    cnt_next  = 3'(cnt_reg - 3'd1);
                    data_next = data_reg >> 8;
                    pos_next  = 6'(pos_reg + 6'd1);
                    len_next  = len_reg + 64'd1;
                end
            end
            ST_PAD:
            begin
                in_pad_next    = 1'b1;
                len_phase_next = len_phase_reg || is_len;
                pad_done_next  = is_len && (pos_reg == LAST_POS);
                pos_next       = 6'(pos_reg + 6'd1);
            end
            ST_PREP:
            begin
                work_next.a = chain_reg[0];
                work_next.b = chain_reg[1];
                work_next.c = chain_reg[2];
                work_next.d = chain_reg[3];
                round_next  = 6'd0;
            end
            ST_ROUND:
            begin
                work_next.a = work_reg.d;
                work_next.b = round_b;
                work_next.c = work_reg.b;
                work_next.d = work_reg.c;
                round_next  = 6'(round_reg + 6'd1);
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
            end
            ST_OUT:
            begin
                // Advance the word; restart the message after the last one
                if (out_fire)
                begin
                    out_idx_next = 2'(out_idx_reg + 2'd1);
                    if (out_idx_reg == LAST_INDEX)
                    begin
                        chain_next[0] = IV0;
                        chain_next[1] = IV1;
                        chain_next[2] = IV2;
                        chain_next[3] = IV3;
                        len_next      = 64'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= IV0;
            chain_reg[1]  <= IV1;
            chain_reg[2]  <= IV2;
            chain_reg[3]  <= IV3;
            len_reg       <= 64'd0;
            pos_reg       <= 6'd0;
            round_reg     <= 6'd0;
            cnt_reg       <= 3'd0;
            eom_reg       <= 1'b0;
            in_pad_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            pad_done_reg  <= 1'b0;
            out_idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            cnt_reg       <= cnt_next;
            eom_reg       <= eom_next;
            in_pad_reg    <= in_pad_next;
            len_phase_reg <= len_phase_next;
            pad_done_reg  <= pad_done_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        work_reg <= work_next;
        if ((state_reg == ST_LOAD && !full_word) || state_reg == ST_PAD)
        begin
            part_reg <= part_next;
        end
    end

    // Block buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            msg_mem[wr_addr] <= wr_data;
        end
        mem_rd_reg <= msg_mem[rd_addr];
    end

    // Digest beat
    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == LAST_INDEX);

endmodule

`default_nettype wire

FILE: design/md5_checker.sv
// ============================================================================
// md5_checker: port-level checks for the MD5 digest block
// Watches the digest beats and the input handshake of the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module md5_checker
    import md5_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [1:0]  word_index,
    input logic        last_word
);

    // Flag the fourth word and only the fourth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == LAST_INDEX)))
        else $error("last_word does not match word_index");

    // Hold a stalled digest beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(digest_word) && $stable(word_index)))
        else $error("stalled digest beat changed");

    // Take no input beat while the digest is going out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during digest output");

    // Step the word index after each non-final beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=>
            (out_valid && word_index == 2'($past(word_index) + 2'd1)))
        else $error("digest beats out of sequence");

endmodule

bind md5_message_digest_top md5_checker u_md5_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

`default_nettype wire
